// ===== rtl/baro_pressure_temp_compensation_top_macros.svh =====
// Assertion macros for the barometric compensation block.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_TOP_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BPTC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("bptc: implication check failed");
`define BPTC_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bptc: invariant check failed");
`else
`define BPTC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BPTC_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/bptc_pkg.sv =====
// Shared types, widths and constants of the barometric compensation pipeline.
`timescale 1ns / 1ps
package bptc_pkg;

    localparam int RAW_W      = 24;
    localparam int COEF_W     = 16;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;
    localparam int REG_IDX_W  = 3;
    localparam int LAT_CYCLES = 10;

    localparam int TOUT_W = 15;
    localparam int POUT_W = 17;

    // shift amounts of the integer scheme
    localparam int SH_C5   = 8;
    localparam int SH_C2   = 16;
    localparam int SH_C1   = 15;
    localparam int SH_TEMP = 23;
    localparam int SH_OFF  = 7;
    localparam int SH_SENS = 8;
    localparam int SH_T2   = 31;
    localparam int SH_P1   = 21;
    localparam int SH_P2   = 15;

    // intermediate widths, sized to the value ranges
    localparam int DT_W    = RAW_W + 1;
    localparam int LIN_W   = DT_W + COEF_W + 1;
    localparam int SQ_W    = 2 * DT_W;
    localparam int DTEMP_W = 18;
    localparam int T2_W    = 17;
    localparam int OFF_W   = 36;
    localparam int SENS_W  = 35;
    localparam int U_W     = DTEMP_W + 1;
    localparam int ASQ_W   = 2 * DTEMP_W;
    localparam int A_W     = ASQ_W - 1;
    localparam int BSQ_W   = 2 * U_W;
    localparam int B_W     = 36;
    localparam int CORR_W  = 40;
    localparam int TEMPF_W = 20;
    localparam int FIN_W   = 42;
    localparam int SPLIT   = SH_P1;
    localparam int HI_W    = FIN_W - SPLIT;
    localparam int PPLO_W  = RAW_W + SPLIT;
    localparam int PPHI_W  = RAW_W + 1 + HI_W;
    localparam int PROD_W  = PPHI_W + SPLIT;
    localparam int X_W     = PROD_W - SH_P1 + 1;
    localparam int P_W     = X_W - SH_P2;

    localparam int TEMP_REF  = 2000;
    localparam int TEMP_COLD = -1500;
    localparam int TEMP_MIN  = -4000;
    localparam int TEMP_MAX  = 8500;
    localparam int PRES_MIN  = 1000;
    localparam int PRES_MAX  = 120000;

    localparam int FROST_OFS = TEMP_REF - TEMP_COLD;
    localparam logic signed [DTEMP_W-1:0] DTEMP_FROST = DTEMP_W'(TEMP_COLD - TEMP_REF);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SENS     = 3'd0,
        REG_OFF      = 3'd1,
        REG_TCS      = 3'd2,
        REG_TCO      = 3'd3,
        REG_TREF     = 3'd4,
        REG_TEMPSENS = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [COEF_W-1:0] sens;
        logic [COEF_W-1:0] off;
        logic [COEF_W-1:0] tcs;
        logic [COEF_W-1:0] tco;
        logic [COEF_W-1:0] tref;
        logic [COEF_W-1:0] tempsens;
    } t_coeffs;

    // first-order results
    typedef struct packed {
        logic                      valid;
        logic [RAW_W-1:0]          d1;
        logic signed [DTEMP_W-1:0] dtemp;
        logic [T2_W-1:0]           t2;
        logic signed [OFF_W-1:0]   off;
        logic signed [SENS_W-1:0]  sens;
    } t_base;

    // second-order corrected results
    typedef struct packed {
        logic                      valid;
        logic [RAW_W-1:0]          d1;
        logic signed [TEMPF_W-1:0] tempf;
        logic signed [FIN_W-1:0]   off_f;
        logic signed [FIN_W-1:0]   sens_f;
    } t_corr;

endpackage

// ===== rtl/bptc_apb_regs.sv =====
// APB register file holding the six calibration words.
`timescale 1ns / 1ps
module bptc_apb_regs
    import bptc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_coeffs           o_coef
);

    t_coeffs  r_coef, n_coef;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;

    always_comb begin
        n_coef = r_coef;
        if (w_wr) begin
            unique case (w_idx)
                REG_SENS:     n_coef.sens     = pwdata[COEF_W-1:0];
                REG_OFF:      n_coef.off      = pwdata[COEF_W-1:0];
                REG_TCS:      n_coef.tcs      = pwdata[COEF_W-1:0];
                REG_TCO:      n_coef.tco      = pwdata[COEF_W-1:0];
                REG_TREF:     n_coef.tref     = pwdata[COEF_W-1:0];
                REG_TEMPSENS: n_coef.tempsens = pwdata[COEF_W-1:0];
                default:      n_coef          = r_coef;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SENS:     prdata = APB_DW'(r_coef.sens);
            REG_OFF:      prdata = APB_DW'(r_coef.off);
            REG_TCS:      prdata = APB_DW'(r_coef.tcs);
            REG_TCO:      prdata = APB_DW'(r_coef.tco);
            REG_TREF:     prdata = APB_DW'(r_coef.tref);
            REG_TEMPSENS: prdata = APB_DW'(r_coef.tempsens);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else begin
            r_coef <= n_coef;
        end
    end

    assign o_coef = r_coef;

endmodule

// ===== rtl/bptc_base.sv =====
// Stages 1-3: temperature difference, linear products, first-order TEMP/OFF/SENS.
`timescale 1ns / 1ps
module bptc_base
    import bptc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [RAW_W-1:0] i_raw_pressure,
    input  logic [RAW_W-1:0] i_raw_temperature,
    input  t_coeffs          i_coef,
    output t_base            o_base
);

    logic                      r_v1, r_v2, r_v3;
    logic [RAW_W-1:0]          r_d1_s1, r_d1_s2, r_d1_s3;
    logic signed [DT_W-1:0]    r_dt, n_dt;
    logic signed [LIN_W-1:0]   r_mt, r_mo, r_ms, n_mt, n_mo, n_ms;
    logic signed [SQ_W-1:0]    r_mdd, n_mdd;
    logic signed [DTEMP_W-1:0] r_dtemp, n_dtemp;
    logic [T2_W-1:0]           r_t2, n_t2;
    logic signed [OFF_W-1:0]   r_off, n_off;
    logic signed [SENS_W-1:0]  r_sens, n_sens;

    always_comb begin
        // dT = D2 - C5 * 2^8
        n_dt = $signed({1'b0, i_raw_temperature})
             - $signed({1'b0, i_coef.tref, {SH_C5{1'b0}}});

        n_mt  = LIN_W'(r_dt) * LIN_W'($signed({1'b0, i_coef.tempsens}));
        n_mo  = LIN_W'(r_dt) * LIN_W'($signed({1'b0, i_coef.tco}));
        n_ms  = LIN_W'(r_dt) * LIN_W'($signed({1'b0, i_coef.tcs}));
        n_mdd = SQ_W'(r_dt) * SQ_W'(r_dt);

        // arithmetic shifts are plain bit selects of the signed products
        n_dtemp = $signed(r_mt[SH_TEMP+DTEMP_W-1:SH_TEMP]);
        n_t2    = r_mdd[SH_T2+T2_W-1:SH_T2];
        n_off   = $signed(OFF_W'({i_coef.off, {SH_C2{1'b0}}}))
                + OFF_W'($signed(r_mo[LIN_W-1:SH_OFF]));
        n_sens  = $signed(SENS_W'({i_coef.sens, {SH_C1{1'b0}}}))
                + SENS_W'($signed(r_ms[LIN_W-1:SH_SENS]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1_s1 <= i_raw_pressure;
        r_dt    <= n_dt;
        r_d1_s2 <= r_d1_s1;
        r_mt    <= n_mt;
        r_mo    <= n_mo;
        r_ms    <= n_ms;
        r_mdd   <= n_mdd;
        r_d1_s3 <= r_d1_s2;
        r_dtemp <= n_dtemp;
        r_t2    <= n_t2;
        r_off   <= n_off;
        r_sens  <= n_sens;
    end

    always_comb begin
        o_base.valid = r_v3;
        o_base.d1    = r_d1_s3;
        o_base.dtemp = r_dtemp;
        o_base.t2    = r_t2;
        o_base.off   = r_off;
        o_base.sens  = r_sens;
    end

endmodule

// ===== rtl/bptc_corr.sv =====
// Stages 4-6: second-order corrections below 20 C and -15 C.
`timescale 1ns / 1ps
module bptc_corr
    import bptc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_base i_base,
    output t_corr o_corr
);

    logic signed [DTEMP_W-1:0] w_dtemp;
    logic signed [OFF_W-1:0]   w_off;
    logic signed [SENS_W-1:0]  w_sens;
    logic signed [ASQ_W-1:0]   w_asq;
    logic signed [U_W-1:0]     w_u;
    logic signed [BSQ_W-1:0]   w_bsq;
    logic [A_W+1:0]            w_a5;
    logic [B_W+2:0]            w_b7;
    logic [B_W+3:0]            w_b11;

    logic                      r_v4, r_v5, r_v6;
    logic [RAW_W-1:0]          r_d1_s4, r_d1_s5, r_d1_s6;
    logic [A_W-1:0]            r_a, n_a;
    logic [B_W-1:0]            r_b, n_b;
    logic                      r_cold, r_frost, n_cold, n_frost;
    logic signed [DTEMP_W-1:0] r_dtemp_s4;
    logic [T2_W-1:0]           r_t2_s4;
    logic signed [OFF_W-1:0]   r_off_s4, r_off_s5;
    logic signed [SENS_W-1:0]  r_sens_s4, r_sens_s5;
    logic [CORR_W-1:0]         r_off2, r_sens2, n_off2, n_sens2;
    logic signed [TEMPF_W-1:0] r_tempf_s5, r_tempf_s6, n_tempf;
    logic signed [FIN_W-1:0]   r_off_f, r_sens_f, n_off_f, n_sens_f;

    assign w_dtemp = i_base.dtemp;
    assign w_off   = i_base.off;
    assign w_sens  = i_base.sens;

    always_comb begin
        // a = (TEMP-2000)^2, b = (TEMP+1500)^2
        w_asq   = ASQ_W'(w_dtemp) * ASQ_W'(w_dtemp);
        w_u     = U_W'(w_dtemp) + U_W'(FROST_OFS);
        w_bsq   = BSQ_W'(w_u) * BSQ_W'(w_u);
        n_a     = w_asq[A_W-1:0];
        n_b     = w_bsq[B_W-1:0];
        n_cold  = w_dtemp[DTEMP_W-1];
        n_frost = w_dtemp < DTEMP_FROST;

        w_a5  = (A_W+2)'({r_a, 2'b00}) + (A_W+2)'(r_a);
        w_b7  = (B_W+3)'({r_b, 3'b000}) - (B_W+3)'(r_b);
        w_b11 = (B_W+4)'({r_b, 3'b000}) + (B_W+4)'({r_b, 1'b0}) + (B_W+4)'(r_b);

        n_off2  = '0;
        n_sens2 = '0;
        if (r_cold) begin
            n_off2  = CORR_W'(w_a5 >> 1) + (r_frost ? CORR_W'(w_b7) : '0);
            n_sens2 = CORR_W'(w_a5 >> 2) + (r_frost ? CORR_W'(w_b11 >> 1) : '0);
        end
        n_tempf = TEMPF_W'(TEMP_REF) + TEMPF_W'(r_dtemp_s4)
                - (r_cold ? TEMPF_W'(r_t2_s4) : '0);

        n_off_f  = FIN_W'(r_off_s5) - FIN_W'(r_off2);
        n_sens_f = FIN_W'(r_sens_s5) - FIN_W'(r_sens2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v4 <= i_base.valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1_s4    <= i_base.d1;
        r_a        <= n_a;
        r_b        <= n_b;
        r_cold     <= n_cold;
        r_frost    <= n_frost;
        r_dtemp_s4 <= w_dtemp;
        r_t2_s4    <= i_base.t2;
        r_off_s4   <= w_off;
        r_sens_s4  <= w_sens;
        r_d1_s5    <= r_d1_s4;
        r_off2     <= n_off2;
        r_sens2    <= n_sens2;
        r_tempf_s5 <= n_tempf;
        r_off_s5   <= r_off_s4;
        r_sens_s5  <= r_sens_s4;
        r_d1_s6    <= r_d1_s5;
        r_tempf_s6 <= r_tempf_s5;
        r_off_f    <= n_off_f;
        r_sens_f   <= n_sens_f;
    end

    always_comb begin
        o_corr.valid  = r_v6;
        o_corr.d1     = r_d1_s6;
        o_corr.tempf  = r_tempf_s6;
        o_corr.off_f  = r_off_f;
        o_corr.sens_f = r_sens_f;
    end

endmodule

// ===== rtl/bptc_press.sv =====
// Stages 7-10: split D1*SENS product, pressure shifts, range clamp and output register.
`timescale 1ns / 1ps
module bptc_press
    import bptc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_corr                    i_corr,
    output logic                     o_done,
    output logic signed [TOUT_W-1:0] o_temperature_c,
    output logic [POUT_W-1:0]        o_pressure_mbar,
    output logic                     o_clamped
);

    logic signed [TEMPF_W-1:0] w_tempf;
    logic signed [FIN_W-1:0]   w_sens_f;
    logic signed [HI_W-1:0]    w_hi;
    logic signed [X_W-1:0]     w_x;
    logic                      w_tlo, w_thi, w_plo, w_phi;

    logic                      r_v7, r_v8, r_v9, r_done;
    logic [PPLO_W-1:0]         r_pp_lo, n_pp_lo;
    logic signed [PPHI_W-1:0]  r_pp_hi, n_pp_hi;
    logic signed [FIN_W-1:0]   r_off_s7, r_off_s8;
    logic signed [TEMPF_W-1:0] r_tempf_s7, r_tempf_s8, r_tempf_s9;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [P_W-1:0]     r_p, n_p;
    logic signed [TOUT_W-1:0]  r_temp_o, n_temp_o;
    logic [POUT_W-1:0]         r_pres_o, n_pres_o;
    logic                      r_clamped_o, n_clamped_o;

    assign w_tempf  = i_corr.tempf;
    assign w_sens_f = i_corr.sens_f;
    assign w_hi     = w_sens_f[FIN_W-1:SPLIT];

    always_comb begin
        // D1 * SENS as two partial products
        n_pp_lo = PPLO_W'(i_corr.d1) * PPLO_W'(w_sens_f[SPLIT-1:0]);
        n_pp_hi = PPHI_W'($signed({1'b0, i_corr.d1})) * PPHI_W'(w_hi);

        n_prod = $signed({r_pp_hi, {SPLIT{1'b0}}}) + $signed(PROD_W'(r_pp_lo));

        w_x = X_W'($signed(r_prod[PROD_W-1:SH_P1])) - X_W'(r_off_s8);
        n_p = $signed(w_x[X_W-1:SH_P2]);

        w_tlo = r_tempf_s9 < TEMPF_W'(TEMP_MIN);
        w_thi = r_tempf_s9 > TEMPF_W'(TEMP_MAX);
        w_plo = r_p < P_W'(PRES_MIN);
        w_phi = r_p > P_W'(PRES_MAX);

        if (w_tlo) begin
            n_temp_o = TOUT_W'(TEMP_MIN);
        end else if (w_thi) begin
            n_temp_o = TOUT_W'(TEMP_MAX);
        end else begin
            n_temp_o = r_tempf_s9[TOUT_W-1:0];
        end
        if (w_plo) begin
            n_pres_o = POUT_W'(PRES_MIN);
        end else if (w_phi) begin
            n_pres_o = POUT_W'(PRES_MAX);
        end else begin
            n_pres_o = r_p[POUT_W-1:0];
        end
        n_clamped_o = w_tlo | w_thi | w_plo | w_phi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7   <= 1'b0;
            r_v8   <= 1'b0;
            r_v9   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v7   <= i_corr.valid;
            r_v8   <= r_v7;
            r_v9   <= r_v8;
            r_done <= r_v9;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp_lo     <= n_pp_lo;
        r_pp_hi     <= n_pp_hi;
        r_off_s7    <= i_corr.off_f;
        r_tempf_s7  <= w_tempf;
        r_prod      <= n_prod;
        r_off_s8    <= r_off_s7;
        r_tempf_s8  <= r_tempf_s7;
        r_p         <= n_p;
        r_tempf_s9  <= r_tempf_s8;
        r_temp_o    <= n_temp_o;
        r_pres_o    <= n_pres_o;
        r_clamped_o <= n_clamped_o;
    end

    assign o_done          = r_done;
    assign o_temperature_c = r_temp_o;
    assign o_pressure_mbar = r_pres_o;
    assign o_clamped       = r_clamped_o;

endmodule

// ===== rtl/baro_pressure_temp_compensation_top.sv =====
// Top level of the barometric pressure and temperature compensation pipeline.
//
// Usage:
//   Calibration words C1..C6 are written over the APB port, one register per
//   word at byte addresses 0, 4, .., 20; only the low 16 bits of pwdata count.
//   Write them while no conversion is in flight.
//   A raw pressure/temperature pair is taken on every clock edge where start
//   is high; busy is never raised, so a new pair may follow every cycle.
//   Each pair produces one result beat: o_done is high for one cycle with
//   temperature (0.01 C), pressure (0.01 mbar) and the clamp flag alongside.
//   Throughput is one pair per cycle. The depth comes from the three
//   multiplier ranks (linear terms with dT squared, the two temperature
//   squares, D1*SENS as two partial products) each with its own register,
//   plus the add/shift/clamp stages between them.
//   Reset clears the calibration words to zero and empties the pipeline.
//   The receiver has no back-pressure: result beats must be taken as they come.
`timescale 1ns / 1ps
`include "baro_pressure_temp_compensation_top_macros.svh"
module baro_pressure_temp_compensation_top
    import bptc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [RAW_W-1:0]         i_raw_pressure,
    input  logic [RAW_W-1:0]         i_raw_temperature,
    output logic                     o_done,
    output logic signed [TOUT_W-1:0] o_temperature_c,
    output logic [POUT_W-1:0]        o_pressure_mbar,
    output logic                     o_clamped,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    t_coeffs w_coef;
    t_base   w_base;
    t_corr   w_corr;
    logic    w_accept;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    bptc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coef  (w_coef)
    );

    bptc_base u_base (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_accept),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_coef            (w_coef),
        .o_base            (w_base)
    );

    bptc_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_base  (w_base),
        .o_corr  (w_corr)
    );

    bptc_press u_press (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_corr          (w_corr),
        .o_done          (o_done),
        .o_temperature_c (o_temperature_c),
        .o_pressure_mbar (o_pressure_mbar),
        .o_clamped       (o_clamped)
    );

    // every accepted pair later comes out as an o_done beat
    `BPTC_ASSERT_IMPLY(a_done_latency, i_clk, i_rst_n, w_accept, ##LAT_CYCLES o_done)

    // a result beat always lies in the sensor range
    `BPTC_ASSERT_IMPLY(a_out_range, i_clk, i_rst_n, o_done,
        (o_temperature_c >= TOUT_W'(TEMP_MIN) && o_temperature_c <= TOUT_W'(TEMP_MAX)
         && o_pressure_mbar >= POUT_W'(PRES_MIN) && o_pressure_mbar <= POUT_W'(PRES_MAX)))

    // the clamp flag means one of the values sits on a limit
    `BPTC_ASSERT_IMPLY(a_clamp_limit, i_clk, i_rst_n, o_done && o_clamped,
        (o_temperature_c == TOUT_W'(TEMP_MIN) || o_temperature_c == TOUT_W'(TEMP_MAX)
         || o_pressure_mbar == POUT_W'(PRES_MIN) || o_pressure_mbar == POUT_W'(PRES_MAX)))

    // no back-pressure toward the sender
    `BPTC_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !busy)

endmodule
